// File: src/sssd_pkg.sv
// Shared constants, types and font table for the seven-segment scan dimmer.
package sssd_pkg;

  localparam int DIGITS_DEF      = 5;
  localparam int STEPS_DEF       = 10;
  localparam int BRIGHT_RESET    = 10;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic CFG_BRIGHT = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  localparam logic [2:0] NO_DIGIT = 3'd7;

  // q = (n * RECIP10) >> RECIP_SHIFT equals n / 10 for every 32-bit n
  localparam logic [63:0] RECIP10     = 64'h0000_0000_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic       vld;
    logic       last;
    logic [2:0] idx;
    logic [3:0] rem;
  } dig_stat_t;

  function automatic logic [7:0] font7(input logic [3:0] d);
    logic [7:0] f;
    unique case (d)
      4'd0:    f = 8'h3F;
      4'd1:    f = 8'h06;
      4'd2:    f = 8'h5B;
      4'd3:    f = 8'h4F;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'h6D;
      4'd6:    f = 8'h7D;
      4'd7:    f = 8'h07;
      4'd8:    f = 8'h7F;
      4'd9:    f = 8'h6F;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

// File: src/sssd_in_if.sv
// Input channel: scan ticks, pattern writes and decimal loads.
interface sssd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  digit_index;
  logic [7:0]  pattern;
  logic [31:0] decimal_value;

  modport source (output valid, kind, digit_index, pattern, decimal_value, input ready);
  modport sink   (input valid, kind, digit_index, pattern, decimal_value, output ready);
endinterface

// File: src/sssd_out_if.sv
// Result channel: drive pin state and pattern readback.
interface sssd_out_if #(parameter int DIGITS = sssd_pkg::DIGITS_DEF);
  logic              valid;
  logic              ready;
  logic [DIGITS-1:0] digit_enables;
  logic [7:0]        segment_lines;
  logic [7:0]        pattern_readback;

  modport source (output valid, digit_enables, segment_lines, pattern_readback, input ready);
  modport sink   (input valid, digit_enables, segment_lines, pattern_readback, output ready);
endinterface

// File: src/seven_segment_scan_dimmer.sv
// Top level of the multiplexed seven-segment scan driver with dimming.
//
//   channel  | dir | handshake        | beat
//   in_bus   | in  | valid/ready      | kind, digit_index, pattern, decimal_value
//   out_bus  | out | valid/ready      | digit_enables, segment_lines, pattern_readback
//   cfg_*    | in  | cfg_we, no stall | cfg_index, cfg_data
//
// Tick, pattern write and idle kinds go from accept through ST_EXEC and ST_DONE to the result.
// A decimal load runs each digit through the shared divide-by-ten unit, in a multiply
// phase and then a remainder phase, while in ST_LOAD and before ST_DONE.
// Synchronous active-low reset clears pins, scan position and pattern store.
// A new beat is taken while a finished result still waits on out_bus.
module seven_segment_scan_dimmer #(
  parameter int DIGITS          = sssd_pkg::DIGITS_DEF,
  parameter int STEPS_PER_DIGIT = sssd_pkg::STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  sssd_in_if.sink    in_bus,
  sssd_out_if.source out_bus
);
  import sssd_pkg::*;

  localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SW = $clog2(STEPS_PER_DIGIT);
  localparam int BRIGHT_RST = (BRIGHT_RESET > STEPS_PER_DIGIT) ? STEPS_PER_DIGIT : BRIGHT_RESET;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        kind_r;
  logic [2:0]        idx_r;
  logic [7:0]        pat_r;
  logic [3:0]        bright_r;
  logic              en_r;
  logic [SW-1:0]     step_r;
  logic [DW-1:0]     digit_r;
  logic [2:0]        last_digit_r;
  logic              last_lit_r;
  logic [7:0]        store_r [DIGITS];
  logic [7:0]        seg_r;
  logic [DIGITS-1:0] dig_pins_r;
  logic              out_valid_r;
  logic [DIGITS-1:0] out_dig_r;
  logic [7:0]        out_seg_r;
  logic [7:0]        out_rb_r;

  logic              in_acc;
  logic              out_free;
  logic              start;
  dig_stat_t         stat;
  logic [3:0]        b_sat;
  logic              lit;
  logic              dchg;
  logic              chg;
  logic [7:0]        cur_pat;
  logic [7:0]        rb;
  logic [DIGITS-1:0] pins_tick;
  logic              do_tick;
  logic              do_write;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign start        = in_acc && (in_bus.kind == KIND_LOAD);
  assign do_tick      = (state_r == ST_EXEC) && (kind_r == KIND_TICK);
  assign do_write     = (state_r == ST_EXEC) && (kind_r == KIND_WRITE);

  sssd_div10 #(.DIGITS(DIGITS)) u_div10 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .value (in_bus.decimal_value),
    .stat  (stat)
  );

  assign b_sat = (5'(cfg_data) > 5'(STEPS_PER_DIGIT)) ? 4'(STEPS_PER_DIGIT) : cfg_data;

  assign lit  = (5'(step_r) < 5'(bright_r)) && en_r;
  assign dchg = (3'(digit_r) != last_digit_r);
  assign chg  = (lit != last_lit_r) || dchg;

  always_comb begin
    cur_pat = 8'd0;
    rb      = 8'd0;
    for (int i = 0; i < DIGITS; i++) begin
      if (digit_r == DW'(i)) begin
        cur_pat = store_r[i];
      end
      if (idx_r == 3'(i)) begin
        rb = store_r[i];
      end
    end
  end

  always_comb begin
    pins_tick = dig_pins_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (chg && dchg && (last_digit_r == 3'(i))) begin
        pins_tick[i] = 1'b0;
      end
      if (chg && (digit_r == DW'(i))) begin
        pins_tick[i] = lit;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_bus.kind == KIND_LOAD) ? ST_LOAD : ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_DONE;
      ST_LOAD: begin
        if (stat.vld && stat.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bright_r     <= 4'(BRIGHT_RST);
      en_r         <= 1'b1;
      step_r       <= '0;
      digit_r      <= '0;
      last_digit_r <= NO_DIGIT;
      last_lit_r   <= 1'b0;
      seg_r        <= 8'd0;
      dig_pins_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= 8'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BRIGHT: bright_r <= b_sat;
          CFG_ENABLE: en_r     <= cfg_data[0];
          default:    en_r     <= en_r;
        endcase
      end
      if (do_tick) begin
        if (step_r == SW'(STEPS_PER_DIGIT - 1)) begin
          step_r  <= '0;
          digit_r <= (digit_r == DW'(DIGITS - 1)) ? '0 : digit_r + DW'(1);
        end else begin
          step_r <= step_r + SW'(1);
        end
        last_digit_r <= 3'(digit_r);
        last_lit_r   <= lit;
        dig_pins_r   <= pins_tick;
        if (chg) begin
          seg_r <= cur_pat;
        end
      end
      for (int i = 0; i < DIGITS; i++) begin
        if (do_write && (idx_r == 3'(i))) begin
          store_r[i] <= pat_r;
        end else if (stat.vld && (stat.idx == 3'(i))) begin
          store_r[i] <= font7(stat.rem);
        end
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_bus.kind;
      idx_r  <= in_bus.digit_index;
      pat_r  <= in_bus.pattern;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_dig_r <= dig_pins_r;
      out_seg_r <= seg_r;
      out_rb_r  <= rb;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.digit_enables    = out_dig_r;
  assign out_bus.segment_lines    = out_seg_r;
  assign out_bus.pattern_readback = out_rb_r;

  a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dig_pins_r))
    else $error("more than one digit driven");

  a_dark_when_unlit: assert property (@(posedge clk) disable iff (!rst_n)
    !last_lit_r |-> (dig_pins_r == '0))
    else $error("digit driven while scan slot is dark");

  a_unit_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    stat.vld |-> (state_r == ST_LOAD))
    else $error("decimal digit produced outside a load");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start work");

endmodule

// File: src/sssd_div10.sv
// Iterative divide-by-ten unit that peels decimal digits off a 32-bit value.
module sssd_div10 #(
  parameter int DIGITS = sssd_pkg::DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         value,
  output sssd_pkg::dig_stat_t stat
);
  import sssd_pkg::*;

  localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic          busy_r, busy_nxt;
  logic          phase_r, phase_nxt;
  logic [31:0]   n_r, n_nxt;
  logic [28:0]   quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   prod;
  logic [3:0]    q10_lo;
  logic          last;

  assign prod   = {32'd0, n_r} * RECIP10;
  assign q10_lo = {quo_r[0], 3'b000} + {quo_r[2:0], 1'b0};
  assign last   = (cnt_r == CW'(DIGITS - 1));

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    n_nxt     = n_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      n_nxt     = value;
      cnt_nxt   = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        quo_nxt   = prod[63:RECIP_SHIFT];
        phase_nxt = 1'b1;
      end else begin
        n_nxt     = {3'b000, quo_r};
        phase_nxt = 1'b0;
        cnt_nxt   = cnt_r + CW'(1);
        if (last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.vld  = busy_r & phase_r;
  assign stat.last = last;
  assign stat.idx  = 3'(cnt_r);
  assign stat.rem  = n_r[3:0] - q10_lo;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the seven-segment scan dimmer: directed and random traffic.
module tb_top;
  import sssd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SLOTS = DIGITS_DEF * STEPS_DEF;
  localparam logic [79:0] FONT_ROM = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                      8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef struct packed {
    logic [DIGITS_DEF-1:0] digit_enables;
    logic [7:0]            segment_lines;
    logic [7:0]            pattern_readback;
  } pin_snapshot_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;

  sssd_in_if                         in_bus ();
  sssd_out_if #(.DIGITS(DIGITS_DEF)) out_bus ();

  seven_segment_scan_dimmer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus.sink),
    .out_bus   (out_bus.source)
  );

  pin_snapshot_t         expected_pins [$];
  int                    fail_count = 0;
  int                    idle_pct = 0;
  int                    stall_pct = 0;

  int                    scan_pos;
  logic [2:0]            shown_digit;
  logic                  shown_lit;
  logic [7:0]            stored_pat [DIGITS_DEF];
  logic [7:0]            seg_state;
  logic [DIGITS_DEF-1:0] dig_state;
  int                    bright_level;
  logic                  display_on;

  always #1 clk = ~clk;

  task automatic reset_display_model();
    scan_pos = 0;
    shown_digit = NO_DIGIT;
    shown_lit = 1'b0;
    for (int i = 0; i < DIGITS_DEF; i++) stored_pat[i] = 8'h00;
    seg_state = 8'h00;
    dig_state = '0;
    bright_level = (BRIGHT_RESET > STEPS_DEF) ? STEPS_DEF : BRIGHT_RESET;
    display_on = 1'b1;
  endtask

  function automatic pin_snapshot_t apply_display_cmd(input logic [1:0] kind,
                                                      input logic [2:0] idx,
                                                      input logic [7:0] pat,
                                                      input logic [31:0] num);
    int            digit;
    int            step;
    logic          lit;
    logic [31:0]   rest;
    pin_snapshot_t snap;
    rest = num;
    if (kind == KIND_TICK) begin
      digit = scan_pos / STEPS_DEF;
      step = scan_pos % STEPS_DEF;
      lit = (step < bright_level) && display_on;
      if (digit >= DIGITS_DEF) digit = 0;
      if (lit != shown_lit || digit != shown_digit) begin
        if (digit != shown_digit && shown_digit < DIGITS_DEF) dig_state[shown_digit] = 1'b0;
        seg_state = stored_pat[digit];
        dig_state[digit] = lit;
      end
      scan_pos = (scan_pos + 1) % SLOTS;
      shown_digit = 3'(digit);
      shown_lit = lit;
    end else if (kind == KIND_WRITE) begin
      if (idx < DIGITS_DEF) stored_pat[idx] = pat;
    end else if (kind == KIND_LOAD) begin
      for (int i = 0; i < DIGITS_DEF; i++) begin
        stored_pat[i] = FONT_ROM[8 * (rest % 10) +: 8];
        rest = rest / 10;
      end
    end
    snap.digit_enables = dig_state;
    snap.segment_lines = seg_state;
    snap.pattern_readback = (idx < DIGITS_DEF) ? stored_pat[idx] : 8'h00;
    return snap;
  endfunction

  task automatic send_beat(input logic [1:0] kind, input logic [2:0] idx,
                           input logic [7:0] pat, input logic [31:0] num);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.kind <= kind;
    in_bus.digit_index <= idx;
    in_bus.pattern <= pat;
    in_bus.decimal_value <= num;
    do @(posedge clk); while (!in_bus.ready);
    expected_pins.push_back(apply_display_cmd(kind, idx, pat, num));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    wait_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_BRIGHT) bright_level = (val > STEPS_DEF) ? STEPS_DEF : int'(val);
    else display_on = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input int idle, input int stall, input logic [3:0] bright,
                                  input logic enable, input int count);
    int          sel;
    logic [1:0]  kind;
    logic [2:0]  idx;
    logic [31:0] num;
    write_reg(CFG_BRIGHT, bright);
    write_reg(CFG_ENABLE, {3'b000, enable});
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(63) == 0) wait_drain();
      sel = $urandom_range(99);
      if (sel < 68) kind = KIND_TICK;
      else if (sel < 84) kind = KIND_WRITE;
      else if (sel < 93) kind = KIND_LOAD;
      else kind = KIND_UNUSED;
      if ($urandom_range(9) < 8) idx = 3'($urandom_range(DIGITS_DEF - 1));
      else idx = 3'($urandom_range(7, DIGITS_DEF));
      case ($urandom_range(3))
        0: num = $urandom;
        1: num = $urandom_range(99999);
        2: num = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        default: num = $urandom_range(9999999);
      endcase
      send_beat(kind, idx, 8'($urandom), num);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_pattern_writes();
    send_beat(KIND_WRITE, 3'd4, 8'h80, 32'h0);
    send_beat(KIND_WRITE, 3'd2, 8'h7F, 32'h0);
    send_beat(KIND_WRITE, 3'd0, 8'hFF, 32'h0);
    send_beat(KIND_WRITE, 3'd7, 8'hFF, 32'h0);
    send_beat(KIND_WRITE, 3'd5, 8'h55, 32'h0);
    send_beat(KIND_UNUSED, 3'd6, 8'hAA, 32'hFFFF_FFFF);
    send_beat(KIND_UNUSED, 3'd0, 8'h00, 32'h0);
    send_beat(KIND_WRITE, 3'd4, 8'h00, 32'h0);
  endtask

  task automatic test_decimal_loads();
    send_beat(KIND_LOAD, 3'd4, 8'h00, 32'hFFFF_FFFF);
    send_beat(KIND_LOAD, 3'd0, 8'hFF, 32'h0);
    send_beat(KIND_LOAD, 3'd2, 8'h00, 32'd90817);
  endtask

  task automatic test_scan_ticks();
    send_beat(KIND_TICK, 3'd0, 8'h00, 32'h0);
    send_beat(KIND_TICK, 3'd1, 8'h00, 32'h0);
    send_beat(KIND_TICK, 3'd0, 8'h00, 32'h0);
    send_beat(KIND_WRITE, 3'd0, 8'h49, 32'h0);
    send_beat(KIND_TICK, 3'd0, 8'h00, 32'h0);
    send_beat(KIND_TICK, 3'd7, 8'h00, 32'h0);
  endtask

  task automatic test_dimming();
    write_reg(CFG_BRIGHT, 4'd0);
    send_beat(KIND_TICK, 3'd0, 8'h00, 32'h0);
    send_beat(KIND_TICK, 3'd3, 8'h00, 32'h0);
    write_reg(CFG_BRIGHT, 4'd15);
    send_beat(KIND_TICK, 3'd1, 8'h00, 32'h0);
    write_reg(CFG_ENABLE, 4'd0);
    send_beat(KIND_TICK, 3'd2, 8'h00, 32'h0);
    write_reg(CFG_ENABLE, 4'd1);
    write_reg(CFG_BRIGHT, 4'd3);
    send_beat(KIND_TICK, 3'd4, 8'h00, 32'h0);
    send_beat(KIND_TICK, 3'd0, 8'h00, 32'h0);
  endtask

  task automatic test_no_idling();
    run_random_phase(0, 0, 4'd10, 1'b1, 260);
  endtask

  task automatic test_sender_idle();
    run_random_phase(85, 0, 4'd4, 1'b1, 260);
  endtask

  task automatic test_receiver_stall();
    run_random_phase(0, 85, 4'd15, 1'b1, 260);
  endtask

  task automatic test_both_idle();
    run_random_phase(27, 27, 4'd1, 1'b1, 260);
    run_random_phase(27, 27, 4'd7, 1'b0, 260);
  endtask

  always @(negedge clk) out_bus.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    pin_snapshot_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_pins.size() == 0) begin
        $error("result beat with no expected pin state pending");
        fail_count++;
      end else begin
        want = expected_pins.pop_front();
        if (out_bus.digit_enables !== want.digit_enables) begin
          $error("digit_enables: expected %h, got %h", want.digit_enables,
                 out_bus.digit_enables);
          fail_count++;
        end
        if (out_bus.segment_lines !== want.segment_lines) begin
          $error("segment_lines: expected %h, got %h", want.segment_lines,
                 out_bus.segment_lines);
          fail_count++;
        end
        if (out_bus.pattern_readback !== want.pattern_readback) begin
          $error("pattern_readback: expected %h, got %h", want.pattern_readback,
                 out_bus.pattern_readback);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BRIGHT;
    cfg_data = 4'd0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_TICK;
    in_bus.digit_index = 3'd0;
    in_bus.pattern = 8'h00;
    in_bus.decimal_value = 32'h0;
    out_bus.ready = 1'b0;
    reset_display_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_pattern_writes();
    test_decimal_loads();
    test_scan_ticks();
    test_dimming();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_drain();
    repeat (20) @(posedge clk);
    if (expected_pins.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: seven_segment_scan_dimmer.f
src/sssd_pkg.sv
src/sssd_in_if.sv
src/sssd_out_if.sv
src/sssd_div10.sv
src/seven_segment_scan_dimmer.sv
tb/tb_top.sv
